@@ sv/hcr_pkg.sv @@
// Shared types and constants for the height color ramp block.
// No dependencies; imported by every module of the block but hcr_fifo.
package hcr_pkg;

  localparam int HCR_FRACTION_BITS = 8;    // default ramp fraction width
  localparam int HEIGHT_W          = 32;   // height and register width
  localparam int MIN_SPAN          = 10;   // narrower spans paint everything blue
  localparam int SEG_SCALE         = 40000; // 4 segments * 10000
  localparam int STRETCH_DEN       = 10001;
  localparam int SCALE_W           = 16;   // SEG_SCALE fits in 16 bits
  localparam int STRETCH_W         = 14;   // STRETCH_DEN fits in 14 bits
  localparam int REM_W             = 48;   // holds num and 2*den
  localparam int MID_DEPTH         = 4;    // queue between front and back
  localparam int CFG_IDX_W         = 1;
  localparam int STOP_COUNT        = 5;
  localparam int STOP_IDX_W        = 3;
  localparam int STOP_LOW          = 0;
  localparam int STOP_HIGH         = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_HEIGHT  = 1'b0,
    CFG_HIGH_HEIGHT = 1'b1
  } cfg_reg_t;

  // How the front classified a height.
  typedef enum logic [1:0] {
    CLS_NARROW,  // span too small
    CLS_BELOW,   // under low_height
    CLS_ABOVE,   // over high_height
    CLS_RANGE    // inside, needs the ramp
  } cls_t;

  typedef struct packed {
    cls_t                  cls;
    logic [HEIGHT_W-1:0]   dz;   // height - low_height, valid for CLS_RANGE
  } item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    rgb_t col;
    logic clamped;
  } result_t;

  localparam rgb_t RAMP_STOPS [STOP_COUNT] = '{
    '{8'd0,   8'd0,   8'd255},   // blue
    '{8'd0,   8'd255, 8'd255},   // cyan
    '{8'd0,   8'd255, 8'd0},     // green
    '{8'd255, 8'd255, 8'd0},     // yellow
    '{8'd255, 8'd0,   8'd0}      // red
  };

endpackage

@@ sv/hcr_fifo.sv @@
// Small register-based queue used between front and back and at the output.
// Depends on nothing; generic over width and depth.
module hcr_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  logic [W-1:0]                   din,
  input  logic                           pop,
  output logic [W-1:0]                   dout,
  output logic                           empty,
  output logic [$clog2(DEPTH+1)-1:0]     count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_pop;

  assign do_pop = pop && (count_r != '0);
  assign empty  = (count_r == '0);
  assign count  = count_r;
  assign dout   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH-1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH-1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (!push && do_pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == CW'(DEPTH)) |-> !push)
    else $error("push into a full queue");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !do_pop) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("queue count did not follow a lone push");

endmodule

@@ sv/hcr_front.sv @@
// Front end: takes heights, classifies them against the configured range.
// Depends on hcr_pkg; feeds the middle queue read by hcr_back.
module hcr_front (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        push,
  input  logic signed [hcr_pkg::HEIGHT_W-1:0]         height,
  input  logic signed [hcr_pkg::HEIGHT_W-1:0]         low_height,
  input  logic signed [hcr_pkg::HEIGHT_W-1:0]         high_height,
  input  logic [$clog2(hcr_pkg::MID_DEPTH+1)-1:0]     mid_count,
  output logic                                        full,
  output logic                                        item_valid,
  output hcr_pkg::item_t                              item,
  output logic [hcr_pkg::HEIGHT_W-1:0]                span
);
  import hcr_pkg::*;

  localparam int CW = $clog2(MID_DEPTH+1);
  localparam int SW = CW + 1;

  logic                       s1_v_r;
  logic signed [HEIGHT_W-1:0] z_r;
  logic                       item_v_r;
  item_t                      item_r, item_nxt;
  logic [HEIGHT_W-1:0]        span_r;
  logic signed [HEIGHT_W:0]   span_w;
  logic [HEIGHT_W-1:0]        dz_w;
  logic [SW-1:0]              credit_sum;
  logic                       accept;

  // credit: queue entries plus beats still in the front stages
  assign credit_sum = SW'(mid_count) + SW'(s1_v_r) + SW'(item_v_r);
  assign full       = (credit_sum >= SW'(MID_DEPTH));
  assign accept     = push && !full;

  assign span_w = {high_height[HEIGHT_W-1], high_height} - {low_height[HEIGHT_W-1], low_height};
  // only used inside the range, where it fits in 32 unsigned bits
  assign dz_w   = z_r - low_height;

  always_comb begin
    item_nxt.dz = dz_w;
    if (span_w < $signed((HEIGHT_W+1)'(MIN_SPAN))) begin
      item_nxt.cls = CLS_NARROW;
    end else if (z_r < low_height) begin
      item_nxt.cls = CLS_BELOW;
    end else if (z_r > high_height) begin
      item_nxt.cls = CLS_ABOVE;
    end else begin
      item_nxt.cls = CLS_RANGE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      item_v_r <= 1'b0;
    end else begin
      s1_v_r   <= accept;
      item_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      z_r <= height;
    end
    item_r <= item_nxt;
    span_r <= span_w[HEIGHT_W-1:0];
  end

  assign item_valid = item_v_r;
  assign item       = item_r;
  assign span       = span_r;

endmodule

@@ sv/hcr_back.sv @@
// Back end: scales the offset, divides by the stretched span one quotient
// bit per stage, and blends the two neighboring ramp stops. Depends on hcr_pkg.
module hcr_back #(
  parameter int FRACTION_BITS = hcr_pkg::HCR_FRACTION_BITS,
  parameter int OUT_DEPTH     = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               mid_empty,
  input  hcr_pkg::item_t                     mid_item,
  input  logic [hcr_pkg::HEIGHT_W-1:0]       span,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]     out_count,
  output logic                               mid_pop,
  output logic                               res_valid,
  output hcr_pkg::result_t                   res
);
  import hcr_pkg::*;

  localparam int F  = FRACTION_BITS;
  localparam int QW = F + 2;                 // two segment bits, F fraction bits
  localparam int CW = $clog2(OUT_DEPTH+1);
  localparam int SW = CW + 1;

  localparam logic [SCALE_W-1:0]   SCALE_C   = SCALE_W'(SEG_SCALE);
  localparam logic [STRETCH_W-1:0] STRETCH_C = STRETCH_W'(STRETCH_DEN);

  logic [REM_W-1:0] den_r;
  logic             mul_v_r;
  cls_t             mul_cls_r;
  logic [REM_W-1:0] num_r;

  logic [QW-1:0]    v_r;
  logic [REM_W-1:0] rem_r [QW];
  logic [QW-1:0]    q_r   [QW];
  cls_t             cls_r [QW];

  logic [REM_W-1:0] rin_w [QW];
  logic [REM_W-1:0] dvs_w [QW];
  logic [QW-1:0]    qin_w [QW];
  logic [QW-1:0]    ge_w;

  logic [SW-1:0]    credit_sum;
  logic [QW-1:0]    q_last;
  logic [1:0]       seg;
  logic [F-1:0]     frac;
  rgb_t             stop_a, stop_b;

  function automatic logic [7:0] mix(input logic [7:0] a, input logic [7:0] b,
                                     input logic [F-1:0] f);
    logic [F+8:0] wa;
    logic [F+8:0] wb;
    logic [F+8:0] s;
    wa = (F+9)'(a) * (F+9)'((F+1)'(1 << F) - (F+1)'(f));
    wb = (F+9)'(b) * (F+9)'(f);
    s  = wa + wb;
    return s[F+7:F];
  endfunction

  // issue only when the output queue has room for everything in flight
  assign credit_sum = SW'(out_count) + SW'(mul_v_r) + SW'($countones(v_r));
  assign mid_pop    = !mid_empty && (credit_sum < SW'(OUT_DEPTH));

  // config-derived divisor, 32 x 14 bits
  always_ff @(posedge clk) begin
    den_r <= REM_W'(span) * REM_W'(STRETCH_C);
  end

  // scale stage, 32 x 16 bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
    end else begin
      mul_v_r <= mid_pop;
    end
  end

  always_ff @(posedge clk) begin
    mul_cls_r <= mid_item.cls;
    num_r     <= REM_W'(mid_item.dz) * REM_W'(SCALE_C);
  end

  // restoring divider: stage 0 tests 2*den, stage 1 den, then shift and test den
  always_comb begin
    rin_w[0] = num_r;
    dvs_w[0] = {den_r[REM_W-2:0], 1'b0};
    qin_w[0] = '0;
    for (int k = 1; k < QW; k++) begin
      if (k == 1) begin
        rin_w[k] = rem_r[k-1];
      end else begin
        rin_w[k] = {rem_r[k-1][REM_W-2:0], 1'b0};
      end
      dvs_w[k] = den_r;
      qin_w[k] = q_r[k-1];
    end
    for (int k = 0; k < QW; k++) begin
      ge_w[k] = (rin_w[k] >= dvs_w[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[QW-2:0], mul_v_r};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QW; k++) begin
      rem_r[k] <= ge_w[k] ? (rin_w[k] - dvs_w[k]) : rin_w[k];
      q_r[k]   <= {qin_w[k][QW-2:0], ge_w[k]};
    end
    cls_r[0] <= mul_cls_r;
    for (int k = 1; k < QW; k++) begin
      cls_r[k] <= cls_r[k-1];
    end
  end

  // blend
  assign q_last = q_r[QW-1];
  assign seg    = q_last[QW-1:F];
  assign frac   = q_last[F-1:0];
  assign stop_a = RAMP_STOPS[STOP_IDX_W'(seg)];
  assign stop_b = RAMP_STOPS[STOP_IDX_W'(seg) + STOP_IDX_W'(1)];

  always_comb begin
    case (cls_r[QW-1])
      CLS_NARROW: begin
        res.col     = RAMP_STOPS[STOP_LOW];
        res.clamped = 1'b0;
      end
      CLS_BELOW: begin
        res.col     = RAMP_STOPS[STOP_LOW];
        res.clamped = 1'b1;
      end
      CLS_ABOVE: begin
        res.col     = RAMP_STOPS[STOP_HIGH];
        res.clamped = 1'b1;
      end
      CLS_RANGE: begin
        res.col.red   = mix(stop_a.red,   stop_b.red,   frac);
        res.col.green = mix(stop_a.green, stop_b.green, frac);
        res.col.blue  = mix(stop_a.blue,  stop_b.blue,  frac);
        res.clamped   = 1'b0;
      end
      default: begin
        res.col     = RAMP_STOPS[STOP_LOW];
        res.clamped = 1'b0;
      end
    endcase
  end

  assign res_valid = v_r[QW-1];

  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    (SW'(out_count) + SW'(mul_v_r) + SW'($countones(v_r))) <= SW'(OUT_DEPTH))
    else $error("output queue credit overrun");

endmodule

@@ sv/height_color_ramp.sv @@
// Height color ramp top level: configuration registers, front, queues, back.
// Depends on hcr_pkg, hcr_fifo, hcr_front and hcr_back.
//
// Maps each height beat to an RGB color on a blue-cyan-green-yellow-red ramp
// spanning [low_height, high_height] (fixed point, 1/1000 unit). Heights outside
// that range saturate to blue or red and set out_clamped; a span under 10 paints
// every point blue with out_clamped low. One height is taken per clock and one
// color delivered per clock, sustained while pop stays high; otherwise the
// queues back up and full stalls the heights. A beat passes from acceptance to
// the result ports through two front stages, the middle queue, the scale stage,
// the divider, which resolves one quotient bit per pipeline stage (FRACTION_BITS
// + 2 stages), and the write into the result queue. Configuration writes take
// effect for beats pushed at the same edge or later, and must only be made while
// no beat is in flight. There is no clearing pass after reset.
module height_color_ramp #(
  parameter int FRACTION_BITS = hcr_pkg::HCR_FRACTION_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // height beats
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [hcr_pkg::HEIGHT_W-1:0]   in_height,
  // color beats
  output logic                                  empty,
  input  logic                                  pop,
  output logic [7:0]                            out_red,
  output logic [7:0]                            out_green,
  output logic [7:0]                            out_blue,
  output logic                                  out_clamped,
  // configuration
  input  logic                                  cfg_we,
  input  logic [hcr_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [hcr_pkg::HEIGHT_W-1:0]          cfg_data
);
  import hcr_pkg::*;

  // back pipeline holds the scale stage plus FRACTION_BITS + 2 divider stages
  localparam int BACK_LAT  = FRACTION_BITS + 3;
  localparam int OUT_DEPTH = 1 << $clog2(BACK_LAT + 2);

  logic signed [HEIGHT_W-1:0] low_r;
  logic signed [HEIGHT_W-1:0] high_r;

  logic                            mid_push;
  item_t                           mid_din;
  item_t                           mid_dout;
  logic                            mid_pop;
  logic                            mid_empty;
  logic [$clog2(MID_DEPTH+1)-1:0]  mid_count;
  logic [HEIGHT_W-1:0]             span;

  logic                            res_valid;
  result_t                         res;
  result_t                         out_res;
  logic [$clog2(OUT_DEPTH+1)-1:0]  out_count;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= '0;
      high_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_LOW_HEIGHT:  low_r  <= cfg_data;
        CFG_HIGH_HEIGHT: high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: accept and classify
  hcr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .height      (in_height),
    .low_height  (low_r),
    .high_height (high_r),
    .mid_count   (mid_count),
    .full        (full),
    .item_valid  (mid_push),
    .item        (mid_din),
    .span        (span)
  );

  // decoupling queue between front and back
  hcr_fifo #(
    .W     ($bits(item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .din   (mid_din),
    .pop   (mid_pop),
    .dout  (mid_dout),
    .empty (mid_empty),
    .count (mid_count)
  );

  // back: divide and blend
  hcr_back #(
    .FRACTION_BITS (FRACTION_BITS),
    .OUT_DEPTH     (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (mid_empty),
    .mid_item  (mid_dout),
    .span      (span),
    .out_count (out_count),
    .mid_pop   (mid_pop),
    .res_valid (res_valid),
    .res       (res)
  );

  // result queue; the back only issues when a slot is reserved here
  hcr_fifo #(
    .W     ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_valid),
    .din   (res),
    .pop   (pop),
    .dout  (out_res),
    .empty (empty),
    .count (out_count)
  );

  assign out_red     = out_res.col.red;
  assign out_green   = out_res.col.green;
  assign out_blue    = out_res.col.blue;
  assign out_clamped = out_res.clamped;

  // a saturated beat always carries one of the end stops
  a_clamp_color: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_clamped) |->
      ((out_red == 8'd255 && out_green == 8'd0 && out_blue == 8'd0) ||
       (out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd255)))
    else $error("clamped beat with a color off the end stops");

endmodule

@@ bench/ramp_color_monitor.sv @@
// Color beat monitor for height_color_ramp: predicts each color from the
// height beats and register writes it sees, then checks the color beats.
// Depends on hcr_pkg for the register index names.
`timescale 1ns / 100ps

module ramp_color_monitor #(
  parameter int FRACTION_BITS = hcr_pkg::HCR_FRACTION_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  logic                           full,
  input  logic [31:0]                    in_height,
  input  logic                           empty,
  input  logic                           pop,
  input  logic [7:0]                     out_red,
  input  logic [7:0]                     out_green,
  input  logic [7:0]                     out_blue,
  input  logic                           out_clamped,
  input  logic                           cfg_we,
  input  logic [hcr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data,
  output int                             fail_count,
  output int                             beats_pending
);
  import hcr_pkg::*;

  localparam longint NARROW_LIMIT = 10;
  localparam longint unsigned RAMP_SCALE = 40000;  // 4 segments, 10000 steps each
  localparam longint unsigned RAMP_STRETCH = 10001;
  localparam int MAX_PRINTS = 40;

  // Stops, blue first; each 24 bits as {red, green, blue}.
  localparam logic [5*24-1:0] STOP_RGB = {
    24'hFF0000, 24'hFFFF00, 24'h00FF00, 24'h00FFFF, 24'h0000FF
  };

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       clamped;
  } color_beat_t;

  logic signed [31:0] low_q;
  logic signed [31:0] high_q;
  color_beat_t        expected_colors[$];
  color_beat_t        want;
  int                 beats_checked;

  function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
                                       input longint unsigned frac);
    longint unsigned one;
    longint unsigned mix;
    one = 64'd1 << FRACTION_BITS;
    mix = (longint'(a) * (one - frac) + longint'(b) * frac) >> FRACTION_BITS;
    return mix[7:0];
  endfunction

  function automatic color_beat_t ramp_color(input logic signed [31:0] lo,
                                             input logic signed [31:0] hi,
                                             input logic signed [31:0] z);
    color_beat_t     c;
    longint          span;
    longint unsigned num;
    longint unsigned den;
    longint unsigned seg;
    longint unsigned frac;
    logic [23:0]     a;
    logic [23:0]     b;
    span = longint'(hi) - longint'(lo);
    c.clamped = 1'b0;
    {c.red, c.green, c.blue} = STOP_RGB[0 +: 24];
    if (span < NARROW_LIMIT) return c;   // narrow or inverted: all blue
    if (z < lo) begin
      c.clamped = 1'b1;
      return c;
    end
    if (z > hi) begin
      {c.red, c.green, c.blue} = STOP_RGB[4*24 +: 24];
      c.clamped = 1'b1;
      return c;
    end
    num  = longint'(z - longint'(lo)) * RAMP_SCALE;
    den  = span * RAMP_STRETCH;
    seg  = num / den;
    frac = ((num % den) << FRACTION_BITS) / den;
    if (seg > 3) begin
      seg  = 3;
      frac = (64'd1 << FRACTION_BITS) - 1;
    end
    a = STOP_RGB[seg*24 +: 24];
    b = STOP_RGB[(seg+1)*24 +: 24];
    c.red   = blend(a[23:16], b[23:16], frac);
    c.green = blend(a[15:8],  b[15:8],  frac);
    c.blue  = blend(a[7:0],   b[7:0],   frac);
    return c;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    if (fail_count < MAX_PRINTS)
      $display("%0t ns color beat %0d: %s got %0d expected %0d",
               $realtime, beats_checked, what, got, exp_val);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      low_q  = '0;
      high_q = '0;
    end else begin
      if (pop && !empty) begin
        if (expected_colors.size() == 0) begin
          report_mismatch("unexpected beat, red", out_red, -1);
        end else begin
          want = expected_colors.pop_front();
          if (out_red !== want.red)         report_mismatch("red", out_red, want.red);
          if (out_green !== want.green)     report_mismatch("green", out_green, want.green);
          if (out_blue !== want.blue)       report_mismatch("blue", out_blue, want.blue);
          if (out_clamped !== want.clamped) report_mismatch("clamped", out_clamped, want.clamped);
        end
        beats_checked++;
      end
      // writes apply to heights taken at the same edge
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_LOW_HEIGHT:  low_q  = cfg_data;
          CFG_HIGH_HEIGHT: high_q = cfg_data;
          default: ;
        endcase
      end
      if (push && !full) expected_colors.push_back(ramp_color(low_q, high_q, in_height));
    end
    beats_pending = expected_colors.size();
  end

endmodule

@@ bench/tb_height_color_ramp.sv @@
// Testbench top for height_color_ramp: clock, reset, height and register
// stimulus, color beat receiver and verdict. Needs hcr_pkg and ramp_color_monitor.
`timescale 1ns / 100ps

module tb_height_color_ramp;
  import hcr_pkg::*;

  localparam int FRACTION_BITS   = HCR_FRACTION_BITS;
  localparam int LATENCY         = FRACTION_BITS + 6;  // edge of push to color visible
  localparam int LIMIT_CYCLES    = 200000;
  localparam int PHASES          = 9;
  localparam int BEATS_PER_PHASE = 50;
  localparam int HOLD_CYCLES     = 150;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 push        = 1'b0;
  logic                 full;
  logic signed [31:0]   in_height   = '0;
  logic                 empty;
  logic                 pop         = 1'b0;
  logic [7:0]           out_red;
  logic [7:0]           out_green;
  logic [7:0]           out_blue;
  logic                 out_clamped;
  logic                 cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = CFG_LOW_HEIGHT;
  logic [31:0]          cfg_data    = '0;

  int fail_count;
  int beats_pending;
  int cycle_count   = 0;
  int tx_idle_pct   = 0;   // chance that the sender idles before a beat, rolled again while it idles
  int rx_idle_pct   = 0;   // chance per cycle that the receiver does not pop
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;

  logic [31:0] cur_lo;     // register values in force, for picking heights
  logic [31:0] cur_hi;

  always #2 clk = ~clk;

  height_color_ramp #(.FRACTION_BITS(FRACTION_BITS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_height  (in_height),
    .empty      (empty),
    .pop        (pop),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .out_clamped(out_clamped),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  ramp_color_monitor #(.FRACTION_BITS(FRACTION_BITS)) u_color_mon (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_height    (in_height),
    .empty        (empty),
    .pop          (pop),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_clamped  (out_clamped),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .beats_pending(beats_pending)
  );

  // Receiver. A hold request makes it refuse to pop until a countdown from HOLD_CYCLES
  // runs out while the sender keeps going, so the block backs up and raises full.
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop       <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      pop          <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      pop <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: a hung block ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // One height beat. Entered and left at a falling edge; push stays high
  // between back-to-back beats so it is never dropped and raised in one step.
  task automatic send_height(input logic [31:0] h);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push      <= 1'b1;
    in_height <= h;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  // Stop sending and wait until every expected color has been popped.
  task automatic drain();
    push <= 1'b0;
    @(negedge clk);
    while (beats_pending != 0) @(negedge clk);
  endtask

  // Block is idle here: write both range registers on consecutive cycles.
  task automatic write_range(input logic [31:0] lo, input logic [31:0] hi);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LOW_HEIGHT;
    cfg_data  <= lo;
    @(negedge clk);
    cfg_index <= CFG_HIGH_HEIGHT;
    cfg_data  <= hi;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    cur_lo = lo;
    cur_hi = hi;
  endtask

  // Random range: mostly sane spans of every magnitude, some narrow,
  // inverted or fully random pairs.
  function automatic void pick_range(output logic [31:0] lo, output logic [31:0] hi);
    longint unsigned span;
    longint unsigned base;
    int              kind;
    kind = $urandom_range(9);
    if (kind == 0) begin
      lo = $urandom;
      hi = lo + $urandom_range(14) - 5;
    end else if (kind == 1) begin
      lo = $urandom;
      hi = $urandom;
    end else begin
      span = 10 + (longint'($urandom) >> $urandom_range(31));
      if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
      base = {$urandom, $urandom} % (64'h1_0000_0000 - span);
      lo   = base[31:0] ^ 32'h8000_0000;   // INT_MIN + base
      hi   = lo + span[31:0];
    end
  endfunction

  // Mostly heights inside the range, some on and just past its ends,
  // the rest any 32-bit value.
  function automatic logic [31:0] pick_height(input logic [31:0] lo, input logic [31:0] hi);
    longint slo;
    longint shi;
    longint unsigned width;
    int     kind;
    slo  = $signed(lo);
    shi  = $signed(hi);
    kind = $urandom_range(99);
    if (shi - slo < 10 || kind < 20) return $urandom;
    if (kind < 32) begin
      case ($urandom_range(3))
        0:       return lo;
        1:       return hi;
        2:       return lo - 32'd1;
        default: return hi + 32'd1;
      endcase
    end
    width = shi - slo + 1;
    return 32'(slo + longint'({$urandom, $urandom} % width));
  endfunction

  initial begin
    logic [31:0] lo;
    logic [31:0] hi;
    cur_lo = '0;
    cur_hi = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 14;
    rx_idle_pct = 52;

    // reset range is zero wide: everything blue, never clamped
    send_height(32'h8000_0000);
    send_height(32'h7FFF_FFFF);
    send_height(32'h0000_0000);

    // symmetric range: both ends, just outside, stop boundaries, extremes
    drain();
    write_range(-32'sd100000, 32'sd100000);
    send_height(-32'sd100000);
    send_height(32'sd100000);
    send_height(-32'sd100001);
    send_height(32'sd100001);
    send_height(32'sd0);
    send_height(-32'sd50000);
    send_height(32'sd50000);
    send_height(32'sd1);
    send_height(32'h8000_0000);
    send_height(32'h7FFF_FFFF);

    // narrowest span that still ramps
    drain();
    write_range(32'd0, 32'd10);
    send_height(32'd0);
    send_height(32'd5);
    send_height(32'd10);
    send_height(32'd11);

    // one short of it: all blue
    drain();
    write_range(32'd0, 32'd9);
    send_height(32'd5);

    // full 32-bit span
    drain();
    write_range(32'h8000_0000, 32'h7FFF_FFFF);
    send_height(32'h8000_0000);
    send_height(32'h7FFF_FFFF);
    send_height(32'h0000_0000);

    // inverted range: all blue
    drain();
    write_range(32'sd1000, -32'sd1000);
    send_height(32'sd0);
    send_height(32'sd1000);

    // random phases: sender idles lightly, then receiver lightly, then neither
    for (int p = 0; p < PHASES; p++) begin
      drain();
      tx_idle_pct = (p < 3) ? 14 : (p < 6) ? 52 : 0;
      rx_idle_pct = (p < 3) ? 52 : (p < 6) ? 14 : 0;
      pick_range(lo, hi);
      write_range(lo, hi);
      if (p == 0 || p == 6) hold_requests++;
      for (int n = 0; n < BEATS_PER_PHASE; n++) send_height(pick_height(cur_lo, cur_hi));
    end

    drain();
    repeat (2 * LATENCY) @(negedge clk);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
